/* rtl/core/keyboard_report_key_event_diff_defines.svh */
// Assertion macros shared by the keyboard report event checker.
// Depends on nothing; the including file supplies clock and reset nets.
`ifndef KEYBOARD_REPORT_KEY_EVENT_DIFF_DEFINES_SVH
`define KEYBOARD_REPORT_KEY_EVENT_DIFF_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define KRED_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define KRED_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/kred_pkg.sv */
// Types and constants for the keyboard report event differ.
// No dependencies; used by the controller, datapath, top level and checker.
`default_nettype none

package kred_pkg;

   localparam int KEY_SLOTS = 6;
   localparam int CODE_W    = 8;

   typedef logic [CODE_W-1:0] code_type;

   localparam logic [1:0] KIND_PRESSED  = 2'd0;
   localparam logic [1:0] KIND_HELD     = 2'd1;
   localparam logic [1:0] KIND_RELEASED = 2'd2;

   localparam code_type MOD_CODE_BASE = 8'hE0;
   localparam int       SPECIAL_BIT   = 3;

   typedef struct packed {
      code_type   code;
      logic [1:0] kind;
      logic       special_change;
      logic       special_level;
   } event_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic evaluate;
      logic step_clear;
      logic step_advance;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic hit;
      logic more_after;
   } status_type;

endpackage

`default_nettype wire

/* rtl/core/keyboard_report_key_event_diff.sv */
// Keyboard report event differ.
// req channel: one boot keyboard report per transfer (modifier byte, six key
// codes). rsp channel: key events, one per transfer, in slot order (release of
// the old code, then press or held of the new code) and then one event per
// modifier bit set in the old or the new report; rsp_last_event marks the
// final event of a report. A report with no changes and no keys down gives
// no transfer at all. The req transfer is captured, the event table is built
// in the EVAL state and the walk loads each event into the output register.
// The walk visits one step per cycle while no event waits on a stalled output
// register, over at most 2*6 + MODIFIER_BITS steps, and stops after the last
// step that has an event. req_stall is high from the transfer until the walk
// is done; the single output register lets the walk finish while its last
// event still waits. While rsp_stall is high the event in the output register
// holds and the walk stops at the next step that has an event.
// Reset (synchronous) clears the previous report to all zeros and empties the
// output register.
// Depends on kred_pkg, kred_ctrl and kred_dp.
`default_nettype none

module keyboard_report_key_event_diff #(
   parameter int MODIFIER_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_modifier_bits,
   input  logic [7:0] req_slot_code_0,
   input  logic [7:0] req_slot_code_1,
   input  logic [7:0] req_slot_code_2,
   input  logic [7:0] req_slot_code_3,
   input  logic [7:0] req_slot_code_4,
   input  logic [7:0] req_slot_code_5,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_event_code,
   output logic [1:0] rsp_event_kind,
   output logic       rsp_special_change,
   output logic       rsp_special_level,
   output logic       rsp_last_event
);
   import kred_pkg::*;

   cmd_type                               cmd;
   status_type                            sts;
   event_type                             rsp_event;
   logic [KEY_SLOTS-1:0][CODE_W-1:0]      slot_codes;

   assign slot_codes[0] = req_slot_code_0;
   assign slot_codes[1] = req_slot_code_1;
   assign slot_codes[2] = req_slot_code_2;
   assign slot_codes[3] = req_slot_code_3;
   assign slot_codes[4] = req_slot_code_4;
   assign slot_codes[5] = req_slot_code_5;

   kred_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   kred_dp #(
      .MODIFIER_BITS (MODIFIER_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_modifier_bits (req_modifier_bits),
      .req_slot_codes    (slot_codes),
      .rsp_event         (rsp_event),
      .rsp_last_event    (rsp_last_event)
   );

   assign rsp_event_code     = rsp_event.code;
   assign rsp_event_kind     = rsp_event.kind;
   assign rsp_special_change = rsp_event.special_change;
   assign rsp_special_level  = rsp_event.special_level;

endmodule

`default_nettype wire

/* rtl/core/kred_dp.sv */
// Datapath: report capture, event table build, step walk and output register.
// Depends on kred_pkg; driven by kred_ctrl through cmd_type / status_type.
`default_nettype none

module kred_dp #(
   parameter int MODIFIER_BITS = 8
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  kred_pkg::cmd_type                                 cmd,
   output kred_pkg::status_type                              sts,
   input  logic [kred_pkg::CODE_W-1:0]                       req_modifier_bits,
   input  logic [kred_pkg::KEY_SLOTS-1:0][kred_pkg::CODE_W-1:0] req_slot_codes,
   output kred_pkg::event_type                               rsp_event,
   output logic                                              rsp_last_event
);
   import kred_pkg::*;

   localparam int STEPS  = 2 * KEY_SLOTS + MODIFIER_BITS;
   localparam int STEP_W = $clog2(STEPS);

   code_type                 cur_codes_ff  [KEY_SLOTS];
   code_type                 prev_codes_ff [KEY_SLOTS];
   logic [MODIFIER_BITS-1:0] cur_mod_ff;
   logic [MODIFIER_BITS-1:0] prev_mod_ff;
   event_type                rec_ff [STEPS];
   event_type                rec_in [STEPS];
   logic [STEPS-1:0]         mask_ff;
   logic [STEPS-1:0]         mask_in;
   logic [STEP_W-1:0]        step_ff;
   event_type                out_ff;
   logic                     last_ff;
   logic                     more_after;

   // Build one record per step: even slot steps release, odd slot steps
   // press or hold, then one step per modifier bit.
   always_comb begin
      logic rel_seen;
      logic held_seen;
      logic was_on;
      logic is_on;
      int   idx;
      mask_in = '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         rel_seen  = 1'b0;
         held_seen = 1'b0;
         for (int k = 0; k < KEY_SLOTS; k++) begin
            if (cur_codes_ff[k] == prev_codes_ff[i]) rel_seen = 1'b1;
            if (prev_codes_ff[k] == cur_codes_ff[i]) held_seen = 1'b1;
         end
         rec_in[2*i].code           = prev_codes_ff[i];
         rec_in[2*i].kind           = KIND_RELEASED;
         rec_in[2*i].special_change = 1'b0;
         rec_in[2*i].special_level  = 1'b0;
         mask_in[2*i]               = (prev_codes_ff[i] != '0) && !rel_seen;
         rec_in[2*i+1].code           = cur_codes_ff[i];
         rec_in[2*i+1].kind           = held_seen ? KIND_HELD : KIND_PRESSED;
         rec_in[2*i+1].special_change = 1'b0;
         rec_in[2*i+1].special_level  = 1'b0;
         mask_in[2*i+1]               = (cur_codes_ff[i] != '0);
      end
      for (int b = 0; b < MODIFIER_BITS; b++) begin
         was_on = prev_mod_ff[b];
         is_on  = cur_mod_ff[b];
         idx    = 2 * KEY_SLOTS + b;
         rec_in[idx].code = MOD_CODE_BASE + CODE_W'(b);
         if (is_on && !was_on) begin
            rec_in[idx].kind = KIND_PRESSED;
         end else if (was_on && !is_on) begin
            rec_in[idx].kind = KIND_RELEASED;
         end else begin
            rec_in[idx].kind = KIND_HELD;
         end
         rec_in[idx].special_change = (b == SPECIAL_BIT) && (was_on != is_on);
         rec_in[idx].special_level  = (b == SPECIAL_BIT) && (was_on != is_on) && is_on;
         mask_in[idx]               = was_on || is_on;
      end
   end

   // any event left beyond the current step
   always_comb begin
      more_after = 1'b0;
      for (int j = 0; j < STEPS; j++) begin
         if (mask_ff[j] && (j > int'(step_ff))) more_after = 1'b1;
      end
   end

   assign sts.hit        = mask_ff[step_ff];
   assign sts.more_after = more_after;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_SLOTS; i++) prev_codes_ff[i] <= '0;
         prev_mod_ff <= '0;
         mask_ff     <= '0;
         step_ff     <= '0;
      end else begin
         if (cmd.evaluate) begin
            // table now holds the old codes, so the history can move on
            for (int i = 0; i < KEY_SLOTS; i++) prev_codes_ff[i] <= cur_codes_ff[i];
            prev_mod_ff <= cur_mod_ff;
            mask_ff     <= mask_in;
         end
         if (cmd.step_clear) begin
            step_ff <= '0;
         end else if (cmd.step_advance) begin
            step_ff <= step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         for (int i = 0; i < KEY_SLOTS; i++) cur_codes_ff[i] <= req_slot_codes[i];
         cur_mod_ff <= req_modifier_bits[MODIFIER_BITS-1:0];
      end
      if (cmd.evaluate) begin
         for (int s = 0; s < STEPS; s++) rec_ff[s] <= rec_in[s];
      end
      if (cmd.load_out) begin
         out_ff  <= rec_ff[step_ff];
         last_ff <= !more_after;
      end
   end

   assign rsp_event      = out_ff;
   assign rsp_last_event = last_ff;

endmodule

`default_nettype wire

/* rtl/core/kred_ctrl.sv */
// Controller: sequences capture, table build and the event walk; owns rsp_valid.
// Depends on kred_pkg; drives kred_dp through cmd_type / status_type.
`default_nettype none

module kred_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output kred_pkg::cmd_type    cmd,
   input  kred_pkg::status_type sts
);
   import kred_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_WALK = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.evaluate   = 1'b1;
            cmd.step_clear = 1'b1;
            state_in       = ST_WALK;
         end
         ST_WALK: begin
            // empty steps pass freely; an event waits for a free output register
            if (!sts.hit || out_free) begin
               if (sts.hit) begin
                  cmd.load_out = 1'b1;
                  rsp_valid_in = 1'b1;
               end
               if (sts.more_after) begin
                  cmd.step_advance = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* rtl/core/kred_checker.sv */
// Port-level checker for the keyboard report event differ, bound to the top.
// Depends on kred_pkg and keyboard_report_key_event_diff_defines.svh.
`default_nettype none

`include "keyboard_report_key_event_diff_defines.svh"

module kred_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_event_code,
   input logic [1:0] rsp_event_kind,
   input logic       rsp_special_change,
   input logic       rsp_special_level
);
   import kred_pkg::*;

   // a stalled event must stay put
   `KRED_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_event_code) && $stable(rsp_event_kind), "rsp event changed while stalled")
   // one report at a time: no second transfer right after one
   `KRED_ASSERT_NEXT(a_req_busy, req_valid && !req_stall, req_stall, "req taken while a report is in work")
   `KRED_ASSERT_NOW(a_kind_legal, rsp_valid, rsp_event_kind != 2'd3, "undefined event kind")
   `KRED_ASSERT_NOW(a_level_needs_change, rsp_valid && rsp_special_level, rsp_special_change, "special level without change")
   // only the special modifier toggling may touch the flag
   `KRED_ASSERT_NOW(a_change_on_special, rsp_valid && rsp_special_change, (rsp_event_code == (MOD_CODE_BASE + 8'(SPECIAL_BIT))) && (rsp_event_kind != KIND_HELD), "special change on wrong event")

endmodule

bind keyboard_report_key_event_diff kred_checker u_kred_checker (.*);

`default_nettype wire
